// ----- src/pdr_pkg.sv -----
// Shared constants for the presence debounce reporter.
package pdr_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int RANGE_WIDTH_DEF = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_ENTER_DELAY  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAVE_DELAY  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_PERIOD = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HB_PERIOD    = 4'd3;

  // Register values after reset.
  localparam logic [CFG_DATA_W-1:0] ENTER_DELAY_RST  = 16'd200;
  localparam logic [CFG_DATA_W-1:0] LEAVE_DELAY_RST  = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RANGE_PERIOD_RST = 16'd200;
  localparam logic [CFG_DATA_W-1:0] HB_PERIOD_RST    = 16'd200;

  // Event kinds carried on the result channel.
  localparam logic [1:0] EV_ENTER     = 2'd0;
  localparam logic [1:0] EV_LEAVE     = 2'd1;
  localparam logic [1:0] EV_RANGE     = 2'd2;
  localparam logic [1:0] EV_HEARTBEAT = 2'd3;

endpackage

// ----- src/pdr_ifs.sv -----
// Channel interfaces of the presence debounce reporter: samples, events, configuration.
interface pdr_in_if #(
  parameter int TIME_WIDTH  = pdr_pkg::TIME_WIDTH_DEF,
  parameter int RANGE_WIDTH = pdr_pkg::RANGE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   sensor_present;
  logic [RANGE_WIDTH-1:0] dist_cm;
  logic [TIME_WIDTH-1:0]  now_ms;

  modport source (output valid, sensor_present, dist_cm, now_ms, input ready);
  modport sink   (input valid, sensor_present, dist_cm, now_ms, output ready);
endinterface

interface pdr_out_if #(
  parameter int TIME_WIDTH  = pdr_pkg::TIME_WIDTH_DEF,
  parameter int RANGE_WIDTH = pdr_pkg::RANGE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             event_kind;
  logic                   present;
  logic [RANGE_WIDTH-1:0] event_range_cm;
  logic [TIME_WIDTH-1:0]  hold_ms;
  logic                   is_last;

  modport source (output valid, event_kind, present, event_range_cm, hold_ms, is_last,
                  input ready);
  modport sink   (input valid, event_kind, present, event_range_cm, hold_ms, is_last,
                  output ready);
endinterface

interface pdr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pdr_pkg::CFG_IDX_W-1:0]    idx;
  logic [pdr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ----- src/presence_debounce_reporter.sv -----
// Top level of the presence debounce reporter: debouncer, range updates and heartbeat.
//
// Usage. Each transfer on in_ch is one radar sample (flag, range, timestamp).
// Every sample yields zero, one or two transfers on out_ch: at most one of
// enter, leave or range update first, then at most one heartbeat; is_last marks
// the final event of a sample. cfg_ch writes the four delay and period
// registers; it is ready whenever reset is released. They must be written only
// while the block is idle; the block itself does not enforce this.
// A taken sample is registered in the input stage and evaluated from there; its
// events are written into the result queue that drives out_ch once they fit.
// Throughput: one sample per cycle while each sample gives at most one event
// and the receiver does not stall; a sample with two events needs two output
// transfers, so the one output transfer per cycle of the two-entry result
// queue sets the rate there.
// Reset (rst_n low at a clock edge) empties the input stage and the result
// queue, sets the debouncer to clear, zeroes all timestamps, forgets the last
// reported range and loads the register defaults. When the receiver stalls,
// results wait in the queue; the input stage still takes a sample as long as
// its events fit in the queue, otherwise in_ch.ready drops.
module presence_debounce_reporter #(
  parameter int TIME_WIDTH  = pdr_pkg::TIME_WIDTH_DEF,
  parameter int RANGE_WIDTH = pdr_pkg::RANGE_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  pdr_in_if.sink  in_ch,
  pdr_out_if.source out_ch,
  pdr_cfg_if.sink cfg_ch
);
  import pdr_pkg::*;

  // Debouncer states; bit 1 set means presence is confirmed.
  localparam logic [1:0] ST_CLEAR       = 2'd0;
  localparam logic [1:0] ST_MAYBE_ENTER = 2'd1;
  localparam logic [1:0] ST_PRESENT     = 2'd2;
  localparam logic [1:0] ST_MAYBE_LEAVE = 2'd3;

  typedef struct packed {
    logic [1:0]             kind;
    logic                   present;
    logic [RANGE_WIDTH-1:0] dist_cm;
    logic [TIME_WIDTH-1:0]  hold_ms;
    logic                   is_last;
  } result_t;

  // Configuration registers. The channel never stalls outside reset.
  logic [CFG_DATA_W-1:0] enter_delay_r, leave_delay_r, range_period_r, hb_period_r;

  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_delay_r  <= ENTER_DELAY_RST;
      leave_delay_r  <= LEAVE_DELAY_RST;
      range_period_r <= RANGE_PERIOD_RST;
      hb_period_r    <= HB_PERIOD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        REG_ENTER_DELAY:  enter_delay_r  <= cfg_ch.data;
        REG_LEAVE_DELAY:  leave_delay_r  <= cfg_ch.data;
        REG_RANGE_PERIOD: range_period_r <= cfg_ch.data;
        REG_HB_PERIOD:    hb_period_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input stage: one registered sample waiting to be evaluated.
  logic                   s1_valid_r;
  logic                   s1_flag_r;
  logic [RANGE_WIDTH-1:0] s1_range_r;
  logic [TIME_WIDTH-1:0]  s1_now_r;

  // Debouncer and reporting state.
  logic [1:0]             st_r, st_nxt;
  logic [TIME_WIDTH-1:0]  cand_start_r, cand_start_nxt;
  logic [TIME_WIDTH-1:0]  state_start_r, state_start_nxt;
  logic [TIME_WIDTH-1:0]  last_hb_r, last_hb_nxt;
  logic [TIME_WIDTH-1:0]  last_emit_r, last_emit_nxt;
  logic                   last_rng_vld_r, last_rng_vld_nxt;
  logic [RANGE_WIDTH-1:0] last_rng_r, last_rng_nxt;

  // Result queue, entry 0 is the head.
  result_t    q_r [2];
  result_t    q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;

  logic       pop;
  logic [1:0] rem;
  logic [1:0] n_res;
  logic       process;

  logic                  raw;
  logic [TIME_WIDTH-1:0] el_cand, el_state, el_emit, el_hb_now, hold_new;
  logic                  ev_vld, hb_vld;
  result_t               ev, hb, r0, r1;

  assign pop = out_ch.valid && out_ch.ready;
  assign rem = cnt_r - {1'b0, pop};

  // All elapsed times wrap with the timestamp width.
  assign raw      = s1_flag_r || (s1_range_r != '0);
  assign el_cand  = s1_now_r - cand_start_r;
  assign el_state = s1_now_r - state_start_r;
  assign el_emit  = s1_now_r - last_emit_r;
  assign el_hb_now = s1_now_r - last_hb_r;

  // Debouncer step: at most one event, plus the updated state.
  always_comb begin
    st_nxt           = st_r;
    cand_start_nxt   = cand_start_r;
    state_start_nxt  = state_start_r;
    last_emit_nxt    = last_emit_r;
    last_rng_vld_nxt = last_rng_vld_r;
    last_rng_nxt     = last_rng_r;
    ev_vld           = 1'b0;
    ev               = '0;
    case (st_r)
      ST_CLEAR: begin
        if (raw) begin
          st_nxt         = ST_MAYBE_ENTER;
          cand_start_nxt = s1_now_r;
        end
      end
      ST_MAYBE_ENTER: begin
        if (!raw) begin
          st_nxt = ST_CLEAR;
        end else if (el_cand >= TIME_WIDTH'(enter_delay_r)) begin
          st_nxt           = ST_PRESENT;
          state_start_nxt  = s1_now_r;
          last_rng_vld_nxt = 1'b1;
          last_rng_nxt     = s1_range_r;
          last_emit_nxt    = s1_now_r;
          ev_vld           = 1'b1;
          ev.kind          = EV_ENTER;
          ev.present       = 1'b1;
          ev.dist_cm       = s1_range_r;
        end
      end
      ST_PRESENT: begin
        if (!raw) begin
          st_nxt         = ST_MAYBE_LEAVE;
          cand_start_nxt = s1_now_r;
        end else if ((s1_range_r != '0)
                     && (!last_rng_vld_r || (s1_range_r != last_rng_r))
                     && (el_emit >= TIME_WIDTH'(range_period_r))) begin
          last_emit_nxt    = s1_now_r;
          last_rng_vld_nxt = 1'b1;
          last_rng_nxt     = s1_range_r;
          ev_vld           = 1'b1;
          ev.kind          = EV_RANGE;
          ev.present       = 1'b1;
          ev.dist_cm       = s1_range_r;
          ev.hold_ms       = el_state;
        end
      end
      default: begin
        if (raw) begin
          st_nxt = ST_PRESENT;
        end else if (el_cand >= TIME_WIDTH'(leave_delay_r)) begin
          st_nxt           = ST_CLEAR;
          state_start_nxt  = s1_now_r;
          last_rng_vld_nxt = 1'b0;
          last_rng_nxt     = '0;
          ev_vld           = 1'b1;
          ev.kind          = EV_LEAVE;
          ev.hold_ms       = el_state;
        end
      end
    endcase
  end

  // The heartbeat sees the state after the debouncer step.
  assign hold_new    = s1_now_r - state_start_nxt;
  assign hb_vld      = el_hb_now >= TIME_WIDTH'(hb_period_r);
  assign last_hb_nxt = hb_vld ? s1_now_r : last_hb_r;

  always_comb begin
    hb          = '0;
    hb.kind     = EV_HEARTBEAT;
    hb.present  = st_nxt[1];
    hb.dist_cm  = s1_range_r;
    hb.hold_ms  = hold_new;
    hb.is_last  = 1'b1;
    r0          = ev_vld ? ev : hb;
    r0.is_last  = !(ev_vld && hb_vld);
    r1          = hb;
  end

  assign n_res = {1'b0, ev_vld} + {1'b0, hb_vld};

  // A sample is evaluated only when all of its events fit in the queue.
  assign process = s1_valid_r && (({1'b0, rem} + {1'b0, n_res}) <= 3'd2);
  assign in_ch.ready = rst_n && (!s1_valid_r || process);

  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    cnt_nxt  = rem;
    if (process) begin
      cnt_nxt = rem + n_res;
      case (rem)
        2'd0: begin
          q_nxt[0] = r0;
          q_nxt[1] = r1;
        end
        2'd1: q_nxt[1] = r0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_flag_r  <= in_ch.sensor_present;
      s1_range_r <= in_ch.dist_cm;
      s1_now_r   <= in_ch.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_CLEAR;
      cand_start_r   <= '0;
      state_start_r  <= '0;
      last_hb_r      <= '0;
      last_emit_r    <= '0;
      last_rng_vld_r <= 1'b0;
      last_rng_r     <= '0;
    end else if (process) begin
      st_r           <= st_nxt;
      cand_start_r   <= cand_start_nxt;
      state_start_r  <= state_start_nxt;
      last_hb_r      <= last_hb_nxt;
      last_emit_r    <= last_emit_nxt;
      last_rng_vld_r <= last_rng_vld_nxt;
      last_rng_r     <= last_rng_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_ch.valid          = cnt_r != 2'd0;
  assign out_ch.event_kind     = q_r[0].kind;
  assign out_ch.present        = q_r[0].present;
  assign out_ch.event_range_cm = q_r[0].dist_cm;
  assign out_ch.hold_ms        = q_r[0].hold_ms;
  assign out_ch.is_last        = q_r[0].is_last;

  // The queue never holds more than two events.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  // With two events queued, the second one always closes a sample.
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> q_r[1].is_last)
    else $error("queue tail is not the last event of a sample");

  // An evaluated sample with events makes the output valid next cycle.
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (process && (n_res != 2'd0)) |=> out_ch.valid)
    else $error("events of an evaluated sample were lost");

  // From clear the debouncer can only stay or become a candidate.
  a_clear_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |=> (st_r == ST_CLEAR || st_r == ST_MAYBE_ENTER))
    else $error("illegal debouncer step out of clear");

  // A sample that cannot be evaluated blocks the input channel.
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !process) |-> !in_ch.ready)
    else $error("input taken while the stage is blocked");

endmodule

// ----- tb/sv/tb_presence_debounce_reporter.sv -----
// Self-checking testbench of the presence debounce reporter with a predicting event scoreboard.
`timescale 1ns / 100ps

import pdr_pkg::*;

// One radar sample as it crosses the input channel.
typedef struct {
  logic        flag;
  logic [15:0] dist_cm;
  logic [31:0] now_ms;
} radar_sample_t;

// One event as it crosses the result channel.
typedef struct {
  logic [1:0]  kind;
  logic        present;
  logic [15:0] dist_cm;
  logic [31:0] hold_ms;
  logic        is_last;
} presence_event_t;

// Debouncer states, in the order the block steps through them.
typedef enum logic [1:0] {
  DB_CLEAR,
  DB_MAYBE_ENTER,
  DB_PRESENT,
  DB_MAYBE_LEAVE
} debounce_state_t;

// Keeps a private copy of the debouncer, works out the events of every
// accepted sample and checks the events that the block delivers against them.
class pdr_event_scoreboard;
  bit [15:0]       enter_delay;
  bit [15:0]       leave_delay;
  bit [15:0]       range_period;
  bit [15:0]       hb_period;
  debounce_state_t db_state;
  bit [31:0]       cand_start;
  bit [31:0]       state_start;
  bit [31:0]       last_hb;
  bit [31:0]       last_range_emit;
  bit              range_known;
  bit [15:0]       reported_cm;
  presence_event_t expected_events[$];
  int              errors;

  function new();
    enter_delay     = ENTER_DELAY_RST;
    leave_delay     = LEAVE_DELAY_RST;
    range_period    = RANGE_PERIOD_RST;
    hb_period       = HB_PERIOD_RST;
    db_state        = DB_CLEAR;
    cand_start      = '0;
    state_start     = '0;
    last_hb         = '0;
    last_range_emit = '0;
    range_known     = 1'b0;
    reported_cm     = '0;
    errors          = 0;
  endfunction

  function bit [31:0] since_ms(bit [31:0] now_t, bit [31:0] then_t);
    return now_t - then_t;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ENTER_DELAY:  enter_delay  = val;
      REG_LEAVE_DELAY:  leave_delay  = val;
      REG_RANGE_PERIOD: range_period = val;
      REG_HB_PERIOD:    hb_period    = val;
      default: ;
    endcase
  endfunction

  function void push_event(ref presence_event_t evs[$], input logic [1:0] kind,
                           input logic pres, input logic [15:0] rng,
                           input logic [31:0] hold);
    presence_event_t e;
    e.kind     = kind;
    e.present  = pres;
    e.dist_cm  = rng;
    e.hold_ms  = hold;
    e.is_last  = 1'b0;
    evs.push_back(e);
  endfunction

  function void note_sample(radar_sample_t s);
    presence_event_t fresh[$];
    bit              raw;
    bit [31:0]       held;
    raw = s.flag || (s.dist_cm != 16'd0);
    case (db_state)
      DB_CLEAR: begin
        if (raw) begin
          db_state   = DB_MAYBE_ENTER;
          cand_start = s.now_ms;
        end
      end
      DB_MAYBE_ENTER: begin
        if (!raw) begin
          db_state = DB_CLEAR;
        end else if (since_ms(s.now_ms, cand_start) >= {16'd0, enter_delay}) begin
          db_state        = DB_PRESENT;
          state_start     = s.now_ms;
          range_known     = 1'b1;
          reported_cm     = s.dist_cm;
          last_range_emit = s.now_ms;
          push_event(fresh, EV_ENTER, 1'b1, s.dist_cm, 32'd0);
        end
      end
      DB_PRESENT: begin
        if (!raw) begin
          db_state   = DB_MAYBE_LEAVE;
          cand_start = s.now_ms;
        end else if (s.dist_cm != 16'd0 && (!range_known || s.dist_cm != reported_cm)) begin
          if (since_ms(s.now_ms, last_range_emit) >= {16'd0, range_period}) begin
            last_range_emit = s.now_ms;
            range_known     = 1'b1;
            reported_cm     = s.dist_cm;
            push_event(fresh, EV_RANGE, 1'b1, s.dist_cm,
                       since_ms(s.now_ms, state_start));
          end
        end
      end
      default: begin
        if (raw) begin
          db_state = DB_PRESENT;
        end else if (since_ms(s.now_ms, cand_start) >= {16'd0, leave_delay}) begin
          held        = since_ms(s.now_ms, state_start);
          db_state    = DB_CLEAR;
          state_start = s.now_ms;
          range_known = 1'b0;
          reported_cm = '0;
          push_event(fresh, EV_LEAVE, 1'b0, 16'd0, held);
        end
      end
    endcase
    if (since_ms(s.now_ms, last_hb) >= {16'd0, hb_period}) begin
      last_hb = s.now_ms;
      push_event(fresh, EV_HEARTBEAT,
                 (db_state == DB_PRESENT || db_state == DB_MAYBE_LEAVE),
                 s.dist_cm, since_ms(s.now_ms, state_start));
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].is_last = 1'b1;
    foreach (fresh[k]) expected_events.push_back(fresh[k]);
  endfunction

  function void check_event(presence_event_t got);
    presence_event_t want;
    if (expected_events.size() == 0) begin
      $error("unexpected event: kind %0d range %0d hold %0d",
             got.kind, got.dist_cm, got.hold_ms);
      errors++;
      return;
    end
    want = expected_events.pop_front();
    if (got.kind !== want.kind) begin
      $error("event_kind expected %0d got %0d", want.kind, got.kind);
      errors++;
    end
    if (got.present !== want.present) begin
      $error("present expected %0d got %0d", want.present, got.present);
      errors++;
    end
    if (got.dist_cm !== want.dist_cm) begin
      $error("event_range_cm expected %0d got %0d", want.dist_cm, got.dist_cm);
      errors++;
    end
    if (got.hold_ms !== want.hold_ms) begin
      $error("hold_ms expected %0d got %0d", want.hold_ms, got.hold_ms);
      errors++;
    end
    if (got.is_last !== want.is_last) begin
      $error("is_last expected %0d got %0d", want.is_last, got.is_last);
      errors++;
    end
  endfunction
endclass

module tb_presence_debounce_reporter;

  // The watchdog gives up after this many cycles without any transfer. The
  // longest legitimate quiet stretch is the receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  // Cycles allowed after the last expected event before the block counts as
  // idle; a sample may still be in flight without producing anything.
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 110;

  logic clk;
  logic rst_n;

  pdr_in_if  in_ch();
  pdr_out_if out_ch();
  pdr_cfg_if cfg_ch();

  presence_debounce_reporter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pdr_event_scoreboard sb;

  // Largest idle gap that each side draws per transfer; zero gives a stretch
  // with no idling at all.
  int tx_idle_max = 7;
  int rx_idle_max = 7;
  // Set by the stimulus to make the receiver stall for a long stretch.
  bit hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitors. They run right after the rising edge, so they see the values
  // that the block itself sampled at that edge.
  always @(posedge clk) begin
    radar_sample_t s;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      s.flag     = in_ch.sensor_present;
      s.dist_cm  = in_ch.dist_cm;
      s.now_ms   = in_ch.now_ms;
      sb.note_sample(s);
    end
  end

  always @(posedge clk) begin
    presence_event_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind     = out_ch.event_kind;
      got.present  = out_ch.present;
      got.dist_cm  = out_ch.event_range_cm;
      got.hold_ms  = out_ch.hold_ms;
      got.is_last  = out_ch.is_last;
      sb.check_event(got);
    end
  end

  // Watchdog. Any transfer on any channel restarts the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Receiver. Before every transfer it idles for a random number of cycles;
  // on request it holds off for a long stretch so that the result queue fills
  // and the block has to drop its input ready.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = $urandom_range(0, rx_idle_max);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Offers one sample after a random gap and returns at the edge of its
  // transfer. Valid stays high when the next sample follows without a gap.
  task automatic send_sample(input logic flag, input logic [15:0] rng,
                             input logic [31:0] t);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sensor_present <= flag;
    in_ch.dist_cm        <= rng;
    in_ch.now_ms         <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops offering samples and waits until every predicted event has come
  // out, then a few cycles more for a sample that produces nothing.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back; only called while idle.
  task automatic write_regs(input logic [15:0] v_enter, input logic [15:0] v_leave,
                            input logic [15:0] v_range, input logic [15:0] v_hb);
    logic [CFG_IDX_W-1:0]  idxs[4];
    logic [CFG_DATA_W-1:0] vals[4];
    idxs[0] = REG_ENTER_DELAY;
    idxs[1] = REG_LEAVE_DELAY;
    idxs[2] = REG_RANGE_PERIOD;
    idxs[3] = REG_HB_PERIOD;
    vals[0] = v_enter;
    vals[1] = v_leave;
    vals[2] = v_range;
    vals[3] = v_hb;
    cfg_ch.valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_ch.idx  <= idxs[k];
      cfg_ch.data <= vals[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      sb.write_reg(idxs[k], vals[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly modest delays so that the debouncer keeps moving, with the two
  // extremes mixed in now and then.
  function automatic logic [15:0] pick_delay();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return 16'd0;
    if (pick == 2) return 16'hFFFF;
    return 16'($urandom_range(1, 300));
  endfunction

  // Alternating runs of presence and absence with advancing timestamps. Most
  // runs are long enough to confirm enter and leave; short glitches inside a
  // run abort candidates, and rare jumps to a random time cover wrap-around
  // and time going backwards.
  task automatic random_phase(input int count, input logic [31:0] start,
                              input int step_max);
    logic [31:0] t;
    logic [15:0] cur_range;
    logic [15:0] rng;
    logic        want;
    logic        pres;
    logic        flag;
    int          run_left;
    t         = start;
    want      = 1'b0;
    run_left  = 0;
    cur_range = 16'($urandom_range(1, 400));
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        want     = ~want;
        run_left = $urandom_range(1, 14);
      end
      run_left--;
      if ($urandom_range(0, 99) < 3)
        t = $urandom;
      else
        t = t + $urandom_range(0, step_max);
      pres = ($urandom_range(0, 9) == 0) ? ~want : want;
      if (pres) begin
        if ($urandom_range(0, 2) == 0)
          cur_range = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                  : 16'($urandom_range(1, 600));
        case ($urandom_range(0, 5))
          0: begin
            flag = 1'b1;
            rng  = 16'd0;
          end
          1: begin
            flag = 1'b0;
            rng  = cur_range;
          end
          default: begin
            flag = 1'b1;
            rng  = cur_range;
          end
        endcase
      end else begin
        flag = 1'b0;
        rng  = 16'd0;
      end
      send_sample(flag, rng, t);
    end
  endtask

  initial begin
    sb = new();
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.sensor_present <= 1'b0;
    in_ch.dist_cm        <= '0;
    in_ch.now_ms         <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.idx           <= '0;
    cfg_ch.data          <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples with the register defaults.
    send_sample(1'b0, 16'd0, 32'd0);          // absent, nothing due yet
    send_sample(1'b1, 16'd0, 32'd10);         // flag alone starts a candidate
    send_sample(1'b1, 16'd0, 32'd100);        // still too early to enter
    send_sample(1'b0, 16'd0, 32'd250);        // candidate aborted, heartbeat
    send_sample(1'b0, 16'hFFFF, 32'd300);     // range alone counts as present
    send_sample(1'b1, 16'hFFFF, 32'd550);     // enter plus heartbeat
    send_sample(1'b1, 16'd1200, 32'd600);     // range change, rate-limited
    send_sample(1'b1, 16'd1200, 32'd800);     // range update now due
    send_sample(1'b1, 16'd1200, 32'd810);     // same range, nothing
    send_sample(1'b1, 16'd0, 32'd820);        // flag alone, no update
    send_sample(1'b0, 16'd0, 32'd830);        // leave candidate
    send_sample(1'b1, 16'd7, 32'd850);        // leave aborted
    send_sample(1'b0, 16'd0, 32'd900);        // new leave candidate
    send_sample(1'b0, 16'd0, 32'd1100);       // leave plus heartbeat
    send_sample(1'b0, 16'd0, 32'd50);         // time went backwards
    send_sample(1'b1, 16'd0, 32'hFFFF_FF00);  // candidate just before wrap
    send_sample(1'b1, 16'd5, 32'h0000_0010);  // enter across the wrap
    drain();

    // Zero delays and periods: every eligible sample fires at once.
    write_regs(16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(1'b0, 16'd0, 32'd5);
    send_sample(1'b1, 16'd7, 32'd5);
    send_sample(1'b1, 16'd7, 32'd5);
    send_sample(1'b1, 16'd9, 32'd5);
    send_sample(1'b0, 16'd0, 32'd5);
    send_sample(1'b0, 16'd0, 32'd5);
    drain();

    // Largest delays: enter lands exactly on the full delay.
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 16'd1, 32'h0000_1000);
    send_sample(1'b1, 16'd1, 32'h0000_1000 + 32'd65534);
    send_sample(1'b1, 16'd2, 32'h0000_1000 + 32'd65535);
    drain();

    // Random phases, each with its own settings and idling pattern. One of
    // them runs the sender flat out while the receiver holds off.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_regs(pick_delay(), pick_delay(), pick_delay(), pick_delay());
      tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      if (p == 2) begin
        tx_idle_max  = 0;
        hold_off_req = 1'b1;
      end
      random_phase(PHASE_ITEMS, ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 : $urandom,
                   $urandom_range(10, 120));
      drain();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/pdr_pkg.sv
src/pdr_ifs.sv
src/presence_debounce_reporter.sv
tb/sv/tb_presence_debounce_reporter.sv
